/* hw/rtl/atfp_pkg.sv */
// Package for the ASCII target frame parser.
// Holds the frame delimiter bytes, the result event codes and fixed field widths.
// No dependencies.
package atfp_pkg;

  localparam logic [7:0] HEAD_BYTE  = 8'h24;
  localparam logic [7:0] TAIL_BYTE  = 8'h23;
  localparam logic [7:0] COMMA_BYTE = 8'h2C;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;

  localparam int NUM_VALUES = 5;
  localparam int NUM_FLAGS  = 6;
  localparam int VALUE_W    = 16;
  localparam int ID_W       = 8;
  localparam int TOTAL_W    = 4;
  localparam int TOTAL_MAX  = 15;
  localparam int COUNT_W    = 32;
  localparam int MIN_FIELDS = 3;

  typedef enum logic [1:0] {
    EV_PARSED    = 2'd0,
    EV_MALFORMED = 2'd1,
    EV_RESTART   = 2'd2,
    EV_OVERLONG  = 2'd3
  } event_t;

endpackage

/* hw/rtl/ascii_target_frame_parser.sv */
// ASCII target frame parser: splits '$'...'#' comma-separated frames byte by byte.
// Depends on atfp_pkg for delimiter bytes, event codes and widths.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data_byte) takes one received byte per
//   transaction. Bytes outside a frame other than '$' are consumed silently.
//   Result channel (out_valid/out_ready/out_*) carries one transaction for every
//   frame ending: tail parsed or malformed, head restart, or overlong drop.
//   Latency: a result appears on the outputs the cycle after its ending byte is
//   accepted. Throughput: one byte per cycle while in_ready is high; the parse state is
//   updated in the accept cycle by one compare and one multiply-by-ten accumulate.
//   The result register is the only output storage: while it holds a result that
//   the receiver has not taken, in_ready is low; it goes high in the cycle the
//   receiver takes it, so a stalled receiver stalls the byte stream.
//   Reset (rst_n low, synchronous) returns to waiting for '$', clears both frame
//   counters and empties the result register.
module ascii_target_frame_parser #(
  parameter int FRAME_LEN  = 128,
  parameter int MAX_FIELDS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_event_res,
  output logic                                  out_is_coordinate,
  output logic [atfp_pkg::ID_W-1:0]             out_function_id,
  output logic signed [atfp_pkg::VALUE_W-1:0]   out_pos_x,
  output logic signed [atfp_pkg::VALUE_W-1:0]   out_pos_y,
  output logic signed [atfp_pkg::VALUE_W-1:0]   out_box_w,
  output logic signed [atfp_pkg::VALUE_W-1:0]   out_box_h,
  output logic [atfp_pkg::TOTAL_W-1:0]          out_field_total,
  output logic [atfp_pkg::COUNT_W-1:0]          out_good_frames,
  output logic [atfp_pkg::COUNT_W-1:0]          out_bad_frames
);

  localparam int BW = $clog2(FRAME_LEN);
  localparam int FW = $clog2(MAX_FIELDS);
  localparam int NV = atfp_pkg::NUM_VALUES;
  localparam int NF = atfp_pkg::NUM_FLAGS;
  localparam int VW = atfp_pkg::VALUE_W;
  localparam int TW = atfp_pkg::TOTAL_W;
  localparam int CW = atfp_pkg::COUNT_W;
  localparam int IW = atfp_pkg::ID_W;

  logic                 in_frame_r, in_frame_nxt;
  logic [BW-1:0]        byte_idx_r, byte_idx_nxt;
  logic [FW-1:0]        field_idx_r, field_idx_nxt;
  logic                 text_ended_r, text_ended_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic                 all_digits_r, all_digits_nxt;
  logic [NF-1:0]        flags_r, flags_nxt;
  logic [VW-1:0]        acc_r [NV];
  logic [VW-1:0]        acc_nxt [NV];
  logic [CW-1:0]        good_cnt_r, good_cnt_nxt;
  logic [CW-1:0]        bad_cnt_r, bad_cnt_nxt;

  logic                 out_valid_r;
  atfp_pkg::event_t     ev_r, ev_nxt;
  logic                 coord_r, coord_nxt;
  logic [IW-1:0]        fid_r, fid_nxt;
  logic [VW-1:0]        pos_x_r, pos_y_r, box_w_r, box_h_r;
  logic [VW-1:0]        pos_x_nxt, pos_y_nxt, box_w_nxt, box_h_nxt;
  logic [TW-1:0]        total_r, total_nxt;

  logic                 take;
  logic                 emit;
  logic                 start;
  logic                 is_digit;
  logic                 field_ok;
  logic [NF-1:0]        closed_flags;
  logic [FW:0]          nfields;
  logic                 good;
  logic                 coord;
  logic [VW-1:0]        acc_step [NV];

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign is_digit = (in_data_byte >= atfp_pkg::DIGIT_LO) && (in_data_byte <= atfp_pkg::DIGIT_HI);
  assign field_ok = nonempty_r && all_digits_r;
  assign nfields  = {1'b0, field_idx_r} + 1'b1;

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      closed_flags[i] = flags_r[i] || (field_ok && (field_idx_r == FW'(i)));
    end
    for (int i = 0; i < NV; i++) begin
      acc_step[i] = {acc_r[i][VW-4:0], 3'b000} + {acc_r[i][VW-2:0], 1'b0}
                  + {{(VW-4){1'b0}}, in_data_byte[3:0]};
    end
  end

  assign good  = (nfields >= (FW+1)'(atfp_pkg::MIN_FIELDS)) && (closed_flags[1:0] == 2'b11);
  assign coord = good && (closed_flags[NF-1:2] == '1);

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_idx_nxt   = byte_idx_r;
    field_idx_nxt  = field_idx_r;
    text_ended_nxt = text_ended_r;
    nonempty_nxt   = nonempty_r;
    all_digits_nxt = all_digits_r;
    flags_nxt      = flags_r;
    for (int i = 0; i < NV; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    good_cnt_nxt = good_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    emit         = 1'b0;
    start        = 1'b0;
    ev_nxt       = atfp_pkg::EV_PARSED;
    coord_nxt    = 1'b0;
    fid_nxt      = '0;
    pos_x_nxt    = '0;
    pos_y_nxt    = '0;
    box_w_nxt    = '0;
    box_h_nxt    = '0;
    total_nxt    = '0;

    if (take) begin
      if (!in_frame_r) begin
        if (in_data_byte == atfp_pkg::HEAD_BYTE) begin
          in_frame_nxt = 1'b1;
          start        = 1'b1;
        end
      end else if (in_data_byte == atfp_pkg::TAIL_BYTE) begin
        emit         = 1'b1;
        start        = 1'b1;
        in_frame_nxt = 1'b0;
        total_nxt    = (nfields > (FW+1)'(atfp_pkg::TOTAL_MAX)) ? TW'(atfp_pkg::TOTAL_MAX)
                                                                 : TW'(nfields);
        if (good) begin
          good_cnt_nxt = good_cnt_r + 1'b1;
          ev_nxt       = atfp_pkg::EV_PARSED;
          coord_nxt    = coord;
          fid_nxt      = acc_r[0][IW-1:0];
          if (coord) begin
            pos_x_nxt = acc_r[1];
            pos_y_nxt = acc_r[2];
            box_w_nxt = acc_r[3];
            box_h_nxt = acc_r[4];
          end
        end else begin
          bad_cnt_nxt = bad_cnt_r + 1'b1;
          ev_nxt      = atfp_pkg::EV_MALFORMED;
        end
      end else if (in_data_byte == atfp_pkg::HEAD_BYTE) begin
        emit        = 1'b1;
        start       = 1'b1;
        bad_cnt_nxt = bad_cnt_r + 1'b1;
        ev_nxt      = atfp_pkg::EV_RESTART;
      end else if (byte_idx_r >= BW'(FRAME_LEN - 1)) begin
        emit         = 1'b1;
        start        = 1'b1;
        in_frame_nxt = 1'b0;
        bad_cnt_nxt  = bad_cnt_r + 1'b1;
        ev_nxt       = atfp_pkg::EV_OVERLONG;
      end else begin
        byte_idx_nxt = byte_idx_r + 1'b1;
        if (!text_ended_r) begin
          if (in_data_byte == atfp_pkg::NUL_BYTE) begin
            text_ended_nxt = 1'b1;
          end else if ((in_data_byte == atfp_pkg::COMMA_BYTE)
                       && (field_idx_r < FW'(MAX_FIELDS - 1))) begin
            flags_nxt      = closed_flags;
            nonempty_nxt   = 1'b0;
            all_digits_nxt = 1'b1;
            field_idx_nxt  = field_idx_r + 1'b1;
          end else begin
            nonempty_nxt = 1'b1;
            if (!is_digit) begin
              all_digits_nxt = 1'b0;
            end else begin
              for (int i = 0; i < NV; i++) begin
                if (field_idx_r == FW'(i + 1)) begin
                  acc_nxt[i] = acc_step[i];
                end
              end
            end
          end
        end
      end
    end

    if (start) begin
      byte_idx_nxt   = '0;
      field_idx_nxt  = '0;
      text_ended_nxt = 1'b0;
      nonempty_nxt   = 1'b0;
      all_digits_nxt = 1'b1;
      flags_nxt      = '0;
      for (int i = 0; i < NV; i++) begin
        acc_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      byte_idx_r   <= '0;
      field_idx_r  <= '0;
      text_ended_r <= 1'b0;
      nonempty_r   <= 1'b0;
      all_digits_r <= 1'b1;
      flags_r      <= '0;
      for (int i = 0; i < NV; i++) begin
        acc_r[i] <= '0;
      end
      good_cnt_r   <= '0;
      bad_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      byte_idx_r   <= byte_idx_nxt;
      field_idx_r  <= field_idx_nxt;
      text_ended_r <= text_ended_nxt;
      nonempty_r   <= nonempty_nxt;
      all_digits_r <= all_digits_nxt;
      flags_r      <= flags_nxt;
      for (int i = 0; i < NV; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      good_cnt_r   <= good_cnt_nxt;
      bad_cnt_r    <= bad_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ev_r    <= ev_nxt;
      coord_r <= coord_nxt;
      fid_r   <= fid_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      box_w_r <= box_w_nxt;
      box_h_r <= box_h_nxt;
      total_r <= total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_is_coordinate = coord_r;
  assign out_function_id   = fid_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_box_w         = box_w_r;
  assign out_box_h         = box_h_r;
  assign out_field_total   = total_r;
  assign out_good_frames   = good_cnt_r;
  assign out_bad_frames    = bad_cnt_r;

endmodule

/* bench/tb_ascii_target_frame_parser.sv */
// Self-checking bench for ascii_target_frame_parser: directed and random '$'...'#' byte streams
// with random idling on both channels, checked against an in-bench frame predictor.
// Depends on atfp_pkg and the ascii_target_frame_parser RTL.
module tb_ascii_target_frame_parser;

  localparam int FRAME_LEN   = 128;
  localparam int MAX_FIELDS  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_ITEMS   = 600;

  typedef struct packed {
    atfp_pkg::event_t                ev;
    logic                            coord;
    logic [atfp_pkg::ID_W-1:0]       fid;
    logic [atfp_pkg::VALUE_W-1:0]    x;
    logic [atfp_pkg::VALUE_W-1:0]    y;
    logic [atfp_pkg::VALUE_W-1:0]    w;
    logic [atfp_pkg::VALUE_W-1:0]    h;
    logic [atfp_pkg::TOTAL_W-1:0]    total;
    logic [atfp_pkg::COUNT_W-1:0]    good;
    logic [atfp_pkg::COUNT_W-1:0]    bad;
  } frame_result_t;

  class frame_scoreboard #(int FRAME_LEN = 128, int MAX_FIELDS = 12);
    bit                              in_frame;
    int                              body_len;
    int                              field_idx;
    bit                              text_done;
    bit                              field_nonempty;
    bit                              field_digits;
    logic [atfp_pkg::NUM_FLAGS-1:0]  numeric;
    logic [atfp_pkg::VALUE_W-1:0]    acc [atfp_pkg::NUM_VALUES];
    logic [atfp_pkg::COUNT_W-1:0]    ok_cnt;
    logic [atfp_pkg::COUNT_W-1:0]    err_cnt;
    frame_result_t                   pending[$];
    int                              mismatches;

    function new();
      in_frame   = 0;
      ok_cnt     = '0;
      err_cnt    = '0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      body_len       = 0;
      field_idx      = 0;
      text_done      = 0;
      field_nonempty = 0;
      field_digits   = 1;
      numeric        = '0;
      for (int i = 0; i < atfp_pkg::NUM_VALUES; i++) acc[i] = '0;
    endfunction

    function void close_field();
      if (field_idx < atfp_pkg::NUM_FLAGS && field_nonempty && field_digits)
        numeric[field_idx] = 1'b1;
      field_nonempty = 0;
      field_digits   = 1;
    endfunction

    function void parse_text(logic [7:0] b);
      if (b == atfp_pkg::NUL_BYTE) begin
        text_done = 1;
      end else if (b == atfp_pkg::COMMA_BYTE && field_idx + 1 < MAX_FIELDS) begin
        close_field();
        field_idx++;
      end else begin
        field_nonempty = 1;
        if (b < atfp_pkg::DIGIT_LO || b > atfp_pkg::DIGIT_HI) begin
          field_digits = 0;
        end else if (field_idx >= 1 && field_idx <= atfp_pkg::NUM_VALUES) begin
          acc[field_idx-1] = acc[field_idx-1] * 16'd10 + 16'(b - atfp_pkg::DIGIT_LO);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t r;
      int            nf;
      bit            good;
      bit            coord;
      r = '0;
      if (!in_frame) begin
        if (b == atfp_pkg::HEAD_BYTE) begin
          in_frame = 1;
          clear_frame();
        end
        return;
      end
      if (b == atfp_pkg::TAIL_BYTE) begin
        close_field();
        nf    = field_idx + 1;
        good  = nf >= atfp_pkg::MIN_FIELDS && numeric[1:0] == 2'b11;
        coord = good && numeric[5:2] == 4'hF;
        if (good) begin
          ok_cnt++;
          r.ev    = atfp_pkg::EV_PARSED;
          r.coord = coord;
          r.fid   = acc[0][atfp_pkg::ID_W-1:0];
          if (coord) begin
            r.x = acc[1];
            r.y = acc[2];
            r.w = acc[3];
            r.h = acc[4];
          end
        end else begin
          err_cnt++;
          r.ev = atfp_pkg::EV_MALFORMED;
        end
        r.total  = (nf > atfp_pkg::TOTAL_MAX) ? atfp_pkg::TOTAL_W'(atfp_pkg::TOTAL_MAX)
                                              : atfp_pkg::TOTAL_W'(nf);
        r.good   = ok_cnt;
        r.bad    = err_cnt;
        in_frame = 0;
        clear_frame();
        pending.push_back(r);
      end else if (b == atfp_pkg::HEAD_BYTE) begin
        err_cnt++;
        clear_frame();
        r.ev   = atfp_pkg::EV_RESTART;
        r.good = ok_cnt;
        r.bad  = err_cnt;
        pending.push_back(r);
      end else if (body_len >= FRAME_LEN - 1) begin
        err_cnt++;
        in_frame = 0;
        clear_frame();
        r.ev   = atfp_pkg::EV_OVERLONG;
        r.good = ok_cnt;
        r.bad  = err_cnt;
        pending.push_back(r);
      end else begin
        body_len++;
        if (!text_done) parse_text(b);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] exp, int idx);
      if (got !== exp)
        report($sformatf("result %0d %s got %0h expected %0h", idx, name, got, exp));
    endtask

    task check_result(frame_result_t got, int idx);
      frame_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", idx));
        return;
      end
      exp = pending.pop_front();
      compare_field("event_res", 32'(got.ev), 32'(exp.ev), idx);
      compare_field("is_coordinate", 32'(got.coord), 32'(exp.coord), idx);
      compare_field("function_id", 32'(got.fid), 32'(exp.fid), idx);
      compare_field("pos_x", 32'(got.x), 32'(exp.x), idx);
      compare_field("pos_y", 32'(got.y), 32'(exp.y), idx);
      compare_field("box_w", 32'(got.w), 32'(exp.w), idx);
      compare_field("box_h", 32'(got.h), 32'(exp.h), idx);
      compare_field("field_total", 32'(got.total), 32'(exp.total), idx);
      compare_field("good_frames", got.good, exp.good, idx);
      compare_field("bad_frames", got.bad, exp.bad, idx);
    endtask
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [7:0]                           in_data_byte;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [1:0]                           out_event_res;
  logic                                 out_is_coordinate;
  logic [atfp_pkg::ID_W-1:0]            out_function_id;
  logic signed [atfp_pkg::VALUE_W-1:0]  out_pos_x;
  logic signed [atfp_pkg::VALUE_W-1:0]  out_pos_y;
  logic signed [atfp_pkg::VALUE_W-1:0]  out_box_w;
  logic signed [atfp_pkg::VALUE_W-1:0]  out_box_h;
  logic [atfp_pkg::TOTAL_W-1:0]         out_field_total;
  logic [atfp_pkg::COUNT_W-1:0]         out_good_frames;
  logic [atfp_pkg::COUNT_W-1:0]         out_bad_frames;

  frame_scoreboard #(FRAME_LEN, MAX_FIELDS) sb;
  logic [7:0] frame_q[$];
  bit         calm;
  bit         reset_done;
  int         sent_items;
  int         cycles;

  ascii_target_frame_parser #(
    .FRAME_LEN (FRAME_LEN),
    .MAX_FIELDS(MAX_FIELDS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_is_coordinate(out_is_coordinate),
    .out_function_id  (out_function_id),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_box_w        (out_box_w),
    .out_box_h        (out_box_h),
    .out_field_total  (out_field_total),
    .out_good_frames  (out_good_frames),
    .out_bad_frames   (out_bad_frames)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data_byte = b;
    in_valid     = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input bit counted);
    while (frame_q.size() > 0) begin
      send_byte(frame_q.pop_front());
      if (counted) sent_items++;
    end
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == atfp_pkg::HEAD_BYTE || b == atfp_pkg::TAIL_BYTE);
    return b;
  endfunction

  task automatic add_digits(input int n);
    repeat (n) frame_q.push_back(atfp_pkg::DIGIT_LO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic add_coord_frame();
    frame_q.push_back(atfp_pkg::HEAD_BYTE);
    add_digits($urandom_range(1, 4));
    frame_q.push_back(atfp_pkg::COMMA_BYTE);
    add_digits($urandom_range(1, 3));
    repeat (4) begin
      frame_q.push_back(atfp_pkg::COMMA_BYTE);
      add_digits($urandom_range(1, 6));
    end
    repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9)) begin
      frame_q.push_back(atfp_pkg::COMMA_BYTE);
      repeat ($urandom_range(0, 3)) frame_q.push_back(junk_byte());
    end
    frame_q.push_back(atfp_pkg::TAIL_BYTE);
  endtask

  task automatic add_message_frame();
    frame_q.push_back(atfp_pkg::HEAD_BYTE);
    add_digits($urandom_range(1, 3));
    frame_q.push_back(atfp_pkg::COMMA_BYTE);
    add_digits($urandom_range(1, 4));
    frame_q.push_back(atfp_pkg::COMMA_BYTE);
    repeat ($urandom_range(0, 10)) frame_q.push_back(junk_byte());
    frame_q.push_back(atfp_pkg::TAIL_BYTE);
  endtask

  task automatic add_broken_frame();
    frame_q.push_back(atfp_pkg::HEAD_BYTE);
    repeat ($urandom_range(1, 15)) begin
      case ($urandom_range(0, 2))
        0: ;
        1: add_digits($urandom_range(1, 5));
        default: repeat ($urandom_range(1, 4)) frame_q.push_back(junk_byte());
      endcase
      frame_q.push_back(atfp_pkg::COMMA_BYTE);
    end
    void'(frame_q.pop_back());
    frame_q.push_back(atfp_pkg::TAIL_BYTE);
  endtask

  task automatic add_nul_frame();
    add_coord_frame();
    void'(frame_q.pop_back());
    frame_q.insert($urandom_range(1, frame_q.size()), atfp_pkg::NUL_BYTE);
    repeat ($urandom_range(0, 3)) frame_q.push_back(junk_byte());
    frame_q.push_back(atfp_pkg::TAIL_BYTE);
  endtask

  task automatic add_long_frame();
    frame_q.push_back(atfp_pkg::HEAD_BYTE);
    repeat ($urandom_range(FRAME_LEN - 3, FRAME_LEN)) begin
      case ($urandom_range(0, 3))
        0: frame_q.push_back(atfp_pkg::COMMA_BYTE);
        1: frame_q.push_back(junk_byte());
        default: add_digits(1);
      endcase
    end
    frame_q.push_back(atfp_pkg::TAIL_BYTE);
  endtask

  initial begin
    frame_result_t got;
    int            stall;
    int            idx;
    out_ready = 1'b0;
    idx       = 0;
    wait (reset_done);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.ev    = atfp_pkg::event_t'(out_event_res);
      got.coord = out_is_coordinate;
      got.fid   = out_function_id;
      got.x     = out_pos_x;
      got.y     = out_pos_y;
      got.w     = out_box_w;
      got.h     = out_box_h;
      got.total = out_field_total;
      got.good  = out_good_frames;
      got.bad   = out_bad_frames;
      sb.check_result(got, idx);
      idx++;
    end
  end

  initial begin
    int pick;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    calm         = 0;
    reset_done   = 0;
    sent_items   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n      = 1'b1;
    reset_done = 1;

    frame_q.push_back(8'hFF);
    frame_q.push_back(atfp_pkg::NUL_BYTE);
    add_text("$1,2#$7,#$1$0,9,");
    frame_q.push_back(atfp_pkg::NUL_BYTE);
    add_text("x#$#");
    send_frame(1);

    while (sent_items < NUM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          logic [7:0] b;
          do b = 8'($urandom_range(0, 255)); while (b == atfp_pkg::HEAD_BYTE);
          frame_q.push_back(b);
        end
        send_frame(0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_coord_frame();
      end else if (pick < 65) begin
        add_message_frame();
      end else if (pick < 87) begin
        add_broken_frame();
      end else if (pick < 93) begin
        frame_q.push_back(atfp_pkg::HEAD_BYTE);
        repeat ($urandom_range(0, 6)) frame_q.push_back(junk_byte());
        add_coord_frame();
      end else if (pick < 97) begin
        add_nul_frame();
      end else begin
        add_long_frame();
      end
      send_frame(1);
    end

    calm     = 0;
    in_valid = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
